>>> rtl/rc4_pkg.sv
package rc4_pkg;

    // Permutation table geometry
    localparam int PERM_SIZE   = 256;
    localparam int PERM_ADDR_W = 8;

    // Key store geometry
    localparam int MAX_KEY_BYTES = 64;
    localparam int KEY_IDX_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KEY_LEN_W     = $clog2(MAX_KEY_BYTES + 1);

    // Keystream bytes thrown away after the key schedule
    localparam int DROP_COUNT = 1024;
    localparam int DROP_W     = $clog2(DROP_COUNT);

    // Configuration register indexes
    localparam logic CFG_KEY_LENGTH   = 1'b0;
    localparam logic CFG_SKIP_DISCARD = 1'b1;

    // Request opcodes; the last one has no meaning and is ignored.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SCHED  = 2'd1,
        OP_CRYPT  = 2'd2,
        OP_UNUSED = 2'd3
    } opcode_t;

    // Operands of the shared byte adder
    typedef struct packed {
        logic [7:0] op_a;
        logic [7:0] op_b;
        logic [7:0] op_c;
    } add_ops_t;

    // Key length as used by the schedule: zero counts as one, large values saturate.
    function automatic logic [KEY_LEN_W-1:0] eff_key_len(input logic [6:0] key_length);
        int unsigned len;
        len = int'(key_length);
        if (len == 0)
        begin
            len = 1;
        end
        if (len > MAX_KEY_BYTES)
        begin
            len = MAX_KEY_BYTES;
        end
        return KEY_LEN_W'(len);
    endfunction

endpackage

>>> rtl/rc4_drop_stream_cipher.sv
// Load-key requests and unused opcodes leave ready high. A crypt request holds ready low
// through GEN_READ, GEN_ADD, GEN_SWAP_J and GEN_SWAP_I and raises its result once the output
// register is free; no request is taken before then. A schedule request holds ready low
// through KS_READ to KS_SWAP_I for all 256 entries, then through the drop of 1024 keystream
// bytes unless skip_discard is set. Reset is asynchronous and active low; it restores the
// identity permutation at once through per-entry valid bits, so no clearing pass is run.
module rc4_drop_stream_cipher
    import rc4_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [6:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [5:0] key_slot,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte
);

    typedef enum logic [3:0] {
        IDLE,
        KS_READ,
        KS_ADD,
        KS_SWAP_J,
        KS_SWAP_I,
        GEN_READ,
        GEN_ADD,
        GEN_SWAP_J,
        GEN_SWAP_I
    } state_t;

    state_t                 state_reg;
    logic [7:0]             i_reg;
    logic [7:0]             j_reg;
    logic [7:0]             a_reg;
    logic [7:0]             b_reg;
    logic [7:0]             t_reg;
    logic [7:0]             data_reg;
    logic [7:0]             out_byte_reg;
    logic                   out_valid_reg;
    logic                   crypt_reg;
    logic [KEY_IDX_W-1:0]   k_reg;
    logic [DROP_W-1:0]      drop_cnt_reg;

    logic [6:0]             key_length_reg;
    logic                   skip_discard_reg;
    logic [KEY_LEN_W-1:0]   key_len_eff;
    logic [KEY_LEN_W-1:0]   k_plus;

    logic                   perm_we;
    logic [PERM_ADDR_W-1:0] perm_waddr;
    logic [7:0]             perm_wdata;
    logic [PERM_ADDR_W-1:0] perm_raddr;
    logic [7:0]             perm_q;
    logic [PERM_SIZE-1:0]   perm_valid_reg;
    logic                   rd_valid_reg;
    logic [PERM_ADDR_W-1:0] rd_addr_reg;
    logic [7:0]             perm_rd;

    logic                   key_we;
    logic [KEY_IDX_W-1:0]   key_waddr;
    logic [7:0]             key_q;

    add_ops_t               add_ops;
    logic [7:0]             add_sum;

    logic                   in_accept;
    logic                   out_free;
    logic                   sched_start;
    logic [7:0]             ks_byte;

    // Handshake
    assign in_ready    = (state_reg == IDLE);
    assign in_accept   = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign out_free    = !out_valid_reg || out_ready;
    assign sched_start = in_accept && (opcode == OP_SCHED);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg   <= 7'd16;
            skip_discard_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_LENGTH:   key_length_reg   <= cfg_wdata;
                CFG_SKIP_DISCARD: skip_discard_reg <= cfg_wdata[0];
            endcase
        end
    end

    // Key cycling during the schedule wraps at the effective key length.
    assign key_len_eff = eff_key_len(key_length_reg);
    assign k_plus      = KEY_LEN_W'(k_reg) + KEY_LEN_W'(1);

    // Key store: a load request writes straight into memory.
    always_comb
    begin
        key_we    = in_accept && (opcode == OP_LOAD) && (int'(key_slot) < MAX_KEY_BYTES);
        key_waddr = KEY_IDX_W'(key_slot);
    end

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (MAX_KEY_BYTES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (data_byte),
        .raddr (k_reg),
        .rdata (key_q)
    );

    // Shared adder operands for the sequencer steps that use the adder.
    always_comb
    begin
        add_ops = '0;
        unique case (state_reg)
            KS_ADD:
            begin
                add_ops.op_a = j_reg;
                add_ops.op_b = perm_rd;
                add_ops.op_c = key_q;
            end
            KS_SWAP_I, GEN_READ:
            begin
                add_ops.op_a = i_reg;
                add_ops.op_b = 8'd1;
            end
            GEN_ADD:
            begin
                add_ops.op_a = j_reg;
                add_ops.op_b = perm_rd;
            end
            GEN_SWAP_J:
            begin
                add_ops.op_a = a_reg;
                add_ops.op_b = perm_rd;
            end
            default:
            begin
                add_ops = '0;
            end
        endcase
    end

    rc4_adder u_adder (
        .ops (add_ops),
        .sum (add_sum)
    );

    // Permutation memory port selection: the swap writes j then i.
    always_comb
    begin
        perm_we    = 1'b0;
        perm_waddr = j_reg;
        perm_wdata = a_reg;
        perm_raddr = i_reg;
        unique case (state_reg)
            KS_ADD, GEN_READ, GEN_ADD, GEN_SWAP_J:
            begin
                perm_raddr = add_sum;
            end
            GEN_SWAP_I:
            begin
                perm_raddr = t_reg;
            end
            default:
            begin
                perm_raddr = i_reg;
            end
        endcase
        if ((state_reg == KS_SWAP_J) || (state_reg == GEN_SWAP_J))
        begin
            perm_we    = 1'b1;
            perm_waddr = j_reg;
            perm_wdata = a_reg;
        end
        else if ((state_reg == KS_SWAP_I) || (state_reg == GEN_SWAP_I))
        begin
            perm_we    = 1'b1;
            perm_waddr = i_reg;
            perm_wdata = b_reg;
        end
    end

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (PERM_SIZE)
    ) u_perm_ram (
        .clk   (clk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .raddr (perm_raddr),
        .rdata (perm_q)
    );

    // Valid bits: an entry never written since reset or schedule reads as its own index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            rd_addr_reg    <= '0;
        end
        else
        begin
            if (sched_start)
            begin
                perm_valid_reg <= '0;
            end
            else if (perm_we)
            begin
                perm_valid_reg[perm_waddr] <= 1'b1;
            end
            rd_valid_reg <= perm_valid_reg[perm_raddr];
            rd_addr_reg  <= perm_raddr;
        end
    end

    assign perm_rd = rd_valid_reg ? perm_q : rd_addr_reg;

    // Keystream tap, taking the two swap writes into account.
    always_comb
    begin
        if (t_reg == j_reg)
        begin
            ks_byte = a_reg;
        end
        else if (t_reg == i_reg)
        begin
            ks_byte = b_reg;
        end
        else
        begin
            ks_byte = perm_rd;
        end
    end

    // Sequencer with its indices, operands and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            t_reg         <= '0;
            data_reg      <= '0;
            out_byte_reg  <= '0;
            out_valid_reg <= 1'b0;
            crypt_reg     <= 1'b0;
            k_reg         <= '0;
            drop_cnt_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (in_accept)
                    begin
                        unique case (opcode)
                            OP_SCHED:
                            begin
                                i_reg     <= '0;
                                j_reg     <= '0;
                                k_reg     <= '0;
                                state_reg <= KS_READ;
                            end
                            OP_CRYPT:
                            begin
                                data_reg  <= data_byte;
                                crypt_reg <= 1'b1;
                                state_reg <= GEN_READ;
                            end
                            default:
                            begin
                                state_reg <= IDLE;
                            end
                        endcase
                    end
                end

                // Key schedule: one table entry per pass through KS_READ, KS_ADD, KS_SWAP_J and KS_SWAP_I.
                KS_READ:
                begin
                    state_reg <= KS_ADD;
                end
                KS_ADD:
                begin
                    a_reg     <= perm_rd;
                    j_reg     <= add_sum;
                    state_reg <= KS_SWAP_J;
                end
                KS_SWAP_J:
                begin
                    b_reg     <= perm_rd;
                    state_reg <= KS_SWAP_I;
                end
                KS_SWAP_I:
                begin
                    i_reg <= add_sum;
                    if (k_plus >= key_len_eff)
                    begin
                        k_reg <= '0;
                    end
                    else
                    begin
                        k_reg <= KEY_IDX_W'(k_plus);
                    end
                    if (i_reg == 8'(PERM_SIZE - 1))
                    begin
                        j_reg        <= '0;
                        drop_cnt_reg <= '0;
                        crypt_reg    <= 1'b0;
                        state_reg    <= skip_discard_reg ? IDLE : GEN_READ;
                    end
                    else
                    begin
                        state_reg <= KS_READ;
                    end
                end

                // Keystream generation, for crypt requests and for the drop.
                GEN_READ:
                begin
                    i_reg     <= add_sum;
                    state_reg <= GEN_ADD;
                end
                GEN_ADD:
                begin
                    a_reg     <= perm_rd;
                    j_reg     <= add_sum;
                    state_reg <= GEN_SWAP_J;
                end
                GEN_SWAP_J:
                begin
                    b_reg     <= perm_rd;
                    t_reg     <= add_sum;
                    state_reg <= GEN_SWAP_I;
                end
                GEN_SWAP_I:
                begin
                    if (crypt_reg)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            out_byte_reg  <= data_reg ^ ks_byte;
                            state_reg     <= IDLE;
                        end
                    end
                    else if (drop_cnt_reg == DROP_W'(DROP_COUNT - 1))
                    begin
                        state_reg <= IDLE;
                    end
                    else
                    begin
                        drop_cnt_reg <= drop_cnt_reg + DROP_W'(1);
                        state_reg    <= GEN_READ;
                    end
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/rc4_ram.sv
module rc4_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/rc4_adder.sv
module rc4_adder
    import rc4_pkg::*;
(
    input  add_ops_t   ops,
    output logic [7:0] sum
);

    // Modulo-256 sum of three bytes, shared by every i, j and tap update.
    assign sum = ops.op_a + ops.op_b + ops.op_c;

endmodule

>>> rtl/rc4_checker.sv
module rc4_checker
    import rc4_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] opcode,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte
);

    // A stalled result holds its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("result changed while stalled");

    // Load requests and unused opcodes leave the block ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_LOAD || opcode == OP_UNUSED) |=> in_ready)
    else $error("single-cycle request left the block busy");

    // A crypt request with no result pending delivers its result after the generation steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_CRYPT && !out_valid |-> ##5 out_valid)
    else $error("crypt result missing");

    // A new result only appears at the end of a busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised without a crypt request in progress");

endmodule

bind rc4_drop_stream_cipher rc4_checker u_rc4_checker (.*);
